/* rtl/srce_pkg.sv */
// srce_pkg: shared types, command codes and default sizes for the small
// RISC core execute block. No dependencies; used by srce_exec and the top.
package srce_pkg;

  localparam int MEM_WORDS_DEF  = 4096;
  localparam int PROG_DEPTH_DEF = 1024;

  // register file is fixed at 32 entries (5-bit register fields)
  localparam int REG_COUNT = 32;
  localparam int REG_AW    = 5;

  localparam int DATA_W    = 32;
  localparam int CMD_W     = 4;
  localparam int ABS_W     = 12;
  localparam int TGT_W     = 10;
  localparam int NPC_OUT_W = 10;
  localparam int MAD_OUT_W = 12;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [DATA_W-1:0] word_t;
  typedef logic [REG_AW-1:0] reg_idx_t;

  localparam cmd_t CMD_ADD  = 4'd0;
  localparam cmd_t CMD_SUB  = 4'd1;
  localparam cmd_t CMD_LD   = 4'd2;
  localparam cmd_t CMD_LW   = 4'd3;
  localparam cmd_t CMD_JAL  = 4'd4;
  localparam cmd_t CMD_ADDI = 4'd5;
  localparam cmd_t CMD_LI   = 4'd6;
  localparam cmd_t CMD_J    = 4'd7;
  localparam cmd_t CMD_BNE  = 4'd8;
  localparam cmd_t CMD_BEQ  = 4'd9;
  localparam cmd_t CMD_BLE  = 4'd10;
  localparam cmd_t CMD_SW   = 4'd11;
  localparam cmd_t CMD_NOP  = 4'd12;

  // side effects decided by the execute stage
  typedef struct packed {
    logic wreg;     // register write
    logic wmem;     // data memory write
    logic is_load;  // write value comes from data memory
  } exec_flags_t;

endpackage

/* rtl/small_risc_core_execute.sv */
// small_risc_core_execute: top level of the single-core execute block.
// Holds the register file, data memory, pc and the three-stage pipeline.
// Depends on srce_pkg and srce_exec.
//
//  Channel | Direction | Handshake         | Beat contents
//  --------+-----------+-------------------+-------------------------------------------
//  in_     | input     | in_valid/in_stall | decoded instruction (cmd, regs, imm, ...)
//  out_    | output    | out_valid/out_stall | next pc, register write, memory write
//
// One beat per cycle sustained while not stalled; a beat passes operand read,
// execute and the result register before it leaves. Data memory and the
// register file use registered reads; results are forwarded from the result
// stage and snooped into the operand stage, so back-to-back dependents never
// stall. After reset a clearing pass zeroes data memory (and the register
// file), one word a cycle: in_stall is high until the pass ends.
// out_stall holds the result stage; earlier stages keep filling until full.
// MEM_WORDS and PROG_DEPTH must be powers of two (addresses wrap by masking).
module small_risc_core_execute #(
  parameter int MEM_WORDS  = srce_pkg::MEM_WORDS_DEF,
  parameter int PROG_DEPTH = srce_pkg::PROG_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // instruction beats
  input  logic                              in_valid,
  output logic                              in_stall,
  input  srce_pkg::cmd_t                    in_cmd,
  input  srce_pkg::reg_idx_t                in_dest_reg,
  input  srce_pkg::reg_idx_t                in_src_a,
  input  srce_pkg::reg_idx_t                in_src_b,
  input  logic signed [srce_pkg::DATA_W-1:0] in_immediate,
  input  logic [srce_pkg::ABS_W-1:0]        in_abs_address,
  input  logic [srce_pkg::TGT_W-1:0]        in_branch_target,
  // result beats
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [srce_pkg::NPC_OUT_W-1:0]    out_next_pc,
  output logic                              out_reg_written,
  output logic signed [srce_pkg::DATA_W-1:0] out_written_value,
  output logic                              out_mem_written,
  output logic [srce_pkg::MAD_OUT_W-1:0]    out_mem_address
);
  import srce_pkg::*;

  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int PC_AW  = $clog2(PROG_DEPTH);

  // ---------------------------------------------------------------------------
  // storage
  // ---------------------------------------------------------------------------
  word_t rf_mem [REG_COUNT];
  word_t dmem   [MEM_WORDS];

  // clearing pass after reset
  logic              clr_busy_r;
  logic [MEM_AW-1:0] clr_addr_r;

  // stage 1: operand read
  logic     s1_v_r;
  cmd_t     s1_cmd_r;
  reg_idx_t s1_rd_r;
  reg_idx_t s1_sa_r;
  reg_idx_t s1_sb_r;
  word_t    s1_imm_r;
  logic [ABS_W-1:0] s1_abs_r;
  logic [TGT_W-1:0] s1_tgt_r;
  word_t    s1_opa_r;
  word_t    s1_opb_r;

  // stage 2: execute
  logic     s2_v_r;
  cmd_t     s2_cmd_r;
  reg_idx_t s2_rd_r;
  reg_idx_t s2_sa_r;
  reg_idx_t s2_sb_r;
  word_t    s2_imm_r;
  logic [ABS_W-1:0] s2_abs_r;
  logic [TGT_W-1:0] s2_tgt_r;
  word_t    s2_opa_r;
  word_t    s2_opb_r;

  logic [PC_AW-1:0] pc_r;

  // stage 3: result register (drives the out_ port)
  logic        s3_v_r;
  exec_flags_t s3_flags_r;
  reg_idx_t    s3_rd_r;
  word_t       s3_val_r;
  word_t       mem_q_r;     // registered data memory read
  logic [NPC_OUT_W-1:0] s3_npc_r;
  logic [MAD_OUT_W-1:0] s3_maddr_r;

  // ---------------------------------------------------------------------------
  // flow control
  // ---------------------------------------------------------------------------
  logic out_acc, in_acc;
  logic s3_free, s2_free, s1_free;
  logic s2_mv, s1_mv;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt;

  assign out_acc = s3_v_r && !out_stall;
  assign s3_free = !s3_v_r || !out_stall;
  assign s2_mv   = s2_v_r && s3_free;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_mv   = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s2_free;
  assign in_stall = clr_busy_r || !s1_free;
  assign in_acc   = in_valid && !in_stall;

  assign s1_v_nxt = in_acc ? 1'b1 : (s1_mv ? 1'b0 : s1_v_r);
  assign s2_v_nxt = s1_mv  ? 1'b1 : (s2_mv ? 1'b0 : s2_v_r);
  assign s3_v_nxt = s2_mv  ? 1'b1 : (out_acc ? 1'b0 : s3_v_r);

  // ---------------------------------------------------------------------------
  // commit: register file is written when the result beat leaves
  // ---------------------------------------------------------------------------
  word_t s3_wval;
  logic  cmt;

  assign s3_wval = s3_flags_r.is_load ? mem_q_r : s3_val_r;
  assign cmt     = out_acc && s3_flags_r.wreg;

  // stage 1 operands pick up a commit landing while they wait
  word_t s1_opa_nxt, s1_opb_nxt;
  assign s1_opa_nxt = (cmt && s3_rd_r == s1_sa_r) ? s3_wval : s1_opa_r;
  assign s1_opb_nxt = (cmt && s3_rd_r == s1_sb_r) ? s3_wval : s1_opb_r;

  // stage 2 operands: forward from the uncommitted result stage
  word_t s2_opa_x, s2_opb_x;
  logic  s3_fwd_ok;
  assign s3_fwd_ok = s3_v_r && s3_flags_r.wreg;
  assign s2_opa_x  = (s3_fwd_ok && s3_rd_r == s2_sa_r) ? s3_wval : s2_opa_r;
  assign s2_opb_x  = (s3_fwd_ok && s3_rd_r == s2_sb_r) ? s3_wval : s2_opb_r;

  // ---------------------------------------------------------------------------
  // execute
  // ---------------------------------------------------------------------------
  exec_flags_t       x_flags;
  word_t             x_wval;
  logic [MEM_AW-1:0] x_maddr;
  logic [PC_AW-1:0]  x_npc;
  word_t             x_npc32;
  word_t             x_maddr32;

  srce_exec #(
    .PC_AW  (PC_AW),
    .MEM_AW (MEM_AW)
  ) u_exec (
    .cmd           (s2_cmd_r),
    .opa           (s2_opa_x),
    .opb           (s2_opb_x),
    .imm           (s2_imm_r),
    .abs_address   (s2_abs_r),
    .branch_target (s2_tgt_r),
    .pc            (pc_r),
    .flags         (x_flags),
    .wval          (x_wval),
    .maddr         (x_maddr),
    .npc           (x_npc)
  );

  assign x_npc32   = word_t'(x_npc);
  assign x_maddr32 = word_t'(x_maddr);

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      pc_r       <= '0;
    end else begin
      if (clr_busy_r) begin
        if (clr_addr_r == MEM_AW'(MEM_WORDS - 1)) clr_busy_r <= 1'b0;
        clr_addr_r <= clr_addr_r + MEM_AW'(1);
      end
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
      if (s2_mv) pc_r <= x_npc;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: register file read with commit bypass
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_cmd;
      s1_rd_r  <= in_dest_reg;
      s1_sa_r  <= in_src_a;
      s1_sb_r  <= in_src_b;
      s1_imm_r <= word_t'(in_immediate);
      s1_abs_r <= in_abs_address;
      s1_tgt_r <= in_branch_target;
      s1_opa_r <= (cmt && s3_rd_r == in_src_a) ? s3_wval : rf_mem[in_src_a];
      s1_opb_r <= (cmt && s3_rd_r == in_src_b) ? s3_wval : rf_mem[in_src_b];
    end else begin
      s1_opa_r <= s1_opa_nxt;
      s1_opb_r <= s1_opb_nxt;
    end
  end

  // register file write port: clearing pass, then commits
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      rf_mem[clr_addr_r[REG_AW-1:0]] <= '0;
    end else if (cmt) begin
      rf_mem[s3_rd_r] <= s3_wval;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2 payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s1_mv) begin
      s2_cmd_r <= s1_cmd_r;
      s2_rd_r  <= s1_rd_r;
      s2_sa_r  <= s1_sa_r;
      s2_sb_r  <= s1_sb_r;
      s2_imm_r <= s1_imm_r;
      s2_abs_r <= s1_abs_r;
      s2_tgt_r <= s1_tgt_r;
      s2_opa_r <= s1_opa_nxt;
      s2_opb_r <= s1_opb_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // data memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      dmem[clr_addr_r] <= '0;
    end else if (s2_mv && x_flags.wmem) begin
      dmem[x_maddr] <= s2_opb_x;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_mv) mem_q_r <= dmem[x_maddr];
  end

  // ---------------------------------------------------------------------------
  // stage 3: result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s2_mv) begin
      s3_flags_r <= x_flags;
      s3_rd_r    <= s2_rd_r;
      s3_val_r   <= x_wval;
      s3_npc_r   <= x_npc32[NPC_OUT_W-1:0];
      s3_maddr_r <= x_flags.wmem ? x_maddr32[MAD_OUT_W-1:0] : '0;
    end
  end

  assign out_valid         = s3_v_r;
  assign out_next_pc       = s3_npc_r;
  assign out_reg_written   = s3_flags_r.wreg;
  assign out_written_value = s3_wval;
  assign out_mem_written   = s3_flags_r.wmem;
  assign out_mem_address   = s3_maddr_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_acc)
    else $error("instruction taken during memory clearing pass");

  a_store_no_regwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mem_written) |-> !out_reg_written)
    else $error("store beat also reports a register write");

  a_idle_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reg_written) |-> (out_written_value == '0))
    else $error("written value nonzero without register write");

  a_store_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_mv && x_flags.wmem) |=> (pc_r == PC_AW'($past(pc_r) + 1'b1)))
    else $error("store did not advance pc by one");

  a_exec_held_only_by_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_mv) |-> (s3_v_r && out_stall))
    else $error("execute stage held without a stalled result");

endmodule

/* rtl/srce_exec.sv */
// srce_exec: combinational execute logic (ALU, address, branch, next pc).
// Depends on srce_pkg.
module srce_exec #(
  parameter int PC_AW  = $clog2(srce_pkg::PROG_DEPTH_DEF),
  parameter int MEM_AW = $clog2(srce_pkg::MEM_WORDS_DEF)
) (
  input  srce_pkg::cmd_t              cmd,
  input  srce_pkg::word_t             opa,
  input  srce_pkg::word_t             opb,
  input  srce_pkg::word_t             imm,
  input  logic [srce_pkg::ABS_W-1:0]  abs_address,
  input  logic [srce_pkg::TGT_W-1:0]  branch_target,
  input  logic [PC_AW-1:0]            pc,
  output srce_pkg::exec_flags_t       flags,
  output srce_pkg::word_t             wval,
  output logic [MEM_AW-1:0]           maddr,
  output logic [PC_AW-1:0]            npc
);
  import srce_pkg::*;

  word_t imm_q;    // imm / 4, truncated toward zero
  word_t eff;      // base + offset word address
  word_t abs32;
  word_t tgt32;
  word_t pc32;
  word_t jal32;
  logic [PC_AW-1:0] pc_inc;
  logic eq;
  logic le;

  assign imm_q  = {{2{imm[31]}}, imm[31:2]} + word_t'(imm[31] && (imm[1:0] != 2'b00));
  assign eff    = opa + imm_q;
  assign abs32  = word_t'(abs_address);
  assign tgt32  = word_t'(branch_target);
  assign pc32   = word_t'(pc);
  assign jal32  = pc32 + imm;
  assign pc_inc = pc + PC_AW'(1);
  assign eq     = (opa == opb);
  assign le     = ($signed(opa) <= $signed(opb));

  always_comb begin
    flags = '0;
    wval  = '0;
    maddr = '0;
    npc   = pc_inc;
    unique case (cmd)
      CMD_ADD: begin
        flags.wreg = 1'b1;
        wval       = opa + opb;
      end
      CMD_SUB: begin
        flags.wreg = 1'b1;
        wval       = opa - opb;
      end
      CMD_LD: begin
        flags.wreg    = 1'b1;
        flags.is_load = 1'b1;
        maddr         = abs32[MEM_AW-1:0];
      end
      CMD_LW: begin
        flags.wreg    = 1'b1;
        flags.is_load = 1'b1;
        maddr         = eff[MEM_AW-1:0];
      end
      CMD_JAL: begin
        flags.wreg = 1'b1;
        wval       = pc32 + word_t'(1);   // link is not wrapped
        npc        = jal32[PC_AW-1:0];
      end
      CMD_ADDI: begin
        flags.wreg = 1'b1;
        wval       = opa + imm;
      end
      CMD_LI: begin
        flags.wreg = 1'b1;
        wval       = imm;
      end
      CMD_J: begin
        npc = tgt32[PC_AW-1:0];
      end
      CMD_BNE: begin
        if (!eq) npc = tgt32[PC_AW-1:0];
      end
      CMD_BEQ: begin
        if (eq) npc = tgt32[PC_AW-1:0];
      end
      CMD_BLE: begin
        if (le) npc = tgt32[PC_AW-1:0];
      end
      CMD_SW: begin
        flags.wmem = 1'b1;
        maddr      = eff[MEM_AW-1:0];
      end
      default: begin
        // no-op and unused codes: pc + 1 only
      end
    endcase
  end

endmodule
